// ----- rtl/mdioe_pkg.sv -----
// shared types and constants of the mdio master with indirect register access
package mdioe_pkg;

  localparam int DIVIDER_BITS = 16;

  localparam logic [4:0]  LOW5_MAX        = 5'h1f;
  localparam logic [4:0]  REG_CTRL        = 5'h0d;
  localparam logic [4:0]  REG_ADDR_DATA   = 5'h0e;
  localparam logic [15:0] CTRL_ADDRESS_FN = 16'h001f;
  localparam logic [15:0] CTRL_DATA_FN    = 16'h401f;
  localparam logic [15:0] DIV_RESET       = 16'h00ff;

  // frame bit positions
  localparam logic [5:0] BIT_START0   = 6'd32;
  localparam logic [5:0] BIT_START1   = 6'd33;
  localparam logic [5:0] BIT_OP0      = 6'd34;
  localparam logic [5:0] BIT_OP1      = 6'd35;
  localparam logic [5:0] BIT_PHY_LAST = 6'd40;
  localparam logic [5:0] BIT_REG_LAST = 6'd45;
  localparam logic [5:0] BIT_TA0      = 6'd46;
  localparam logic [5:0] BIT_TA1      = 6'd47;
  localparam logic [5:0] BIT_LAST     = 6'd63;

  localparam logic [1:0] STEP_LAST = 2'd3;

  typedef enum logic [1:0] {
    STEP_ADDR_FN = 2'd0,
    STEP_ADDR    = 2'd1,
    STEP_DATA_FN = 2'd2,
    STEP_ACCESS  = 2'd3
  } frame_step_t;

  typedef enum logic [0:0] {
    CFG_CLOCK_DIVIDER = 1'b0,
    CFG_ENABLE        = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ACK   = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    logic        operation;
    logic        is_write;
    logic [4:0]  phy_address;
    logic [7:0]  register_address;
    logic [15:0] write_data;
    logic        mdio_in;
  } req_t;

  typedef struct packed {
    logic        mdc;
    logic        mdio_out;
    logic        mdio_drive;
    logic        busy_res;
    logic        done_res;
    logic        acknowledged;
    logic [15:0] read_data;
    status_t     status;
  } res_t;

  typedef struct packed {
    cfg_index_t  index;
    logic [15:0] value;
  } cfg_t;

  // what the current frame carries
  typedef struct packed {
    logic        is_write;
    logic [4:0]  phy;
    logic [4:0]  reg_addr;
    logic [15:0] data;
  } frame_sel_t;

  typedef struct packed {
    logic level;
    logic drive;
  } line_t;

endpackage

// ----- rtl/mdioe_ifs.sv -----
// valid/ready channels for requests, results and register writes
interface mdioe_req_if;
  import mdioe_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mdioe_res_if;
  import mdioe_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mdioe_cfg_if;
  import mdioe_pkg::*;
  logic valid;
  logic ready;
  cfg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/mdio_master_extended_access_core.sv -----
// mdio master top: request handling, bit timing, frame sequencing, result register
// latency: the result of a request is in the result register in the cycle after it is accepted
// throughput: one request per cycle unless a result waits; each tick steps mdc by one count
// a frame bit lasts divider+1 tick requests, one frame 64 bits, indirect access four frames
// reset: synchronous; divider back to 255, master disabled, bus idle, result register empty
module mdio_master_extended_access_core (
  input logic        clk,
  input logic        rst,
  mdioe_cfg_if.sink  cfg,
  mdioe_req_if.sink  req,
  mdioe_res_if.source res
);
  import mdioe_pkg::*;

  logic [15:0] clock_divider;
  logic        enable;

  logic [15:0] tick_count, tick_count_next;
  logic [5:0]  bit_index, bit_index_next;
  frame_step_t frame_step, frame_step_next;
  logic        active, active_next;
  logic        extended_mode, extended_mode_next;
  logic        ack_seen, ack_seen_next;
  logic [15:0] shift_register, shift_register_next;

  logic        held_write;
  logic [4:0]  held_phy;
  logic [7:0]  held_reg;
  logic [15:0] held_data;

  logic        out_valid;
  res_t        out_data, result;

  logic        accept;
  logic        load_request;

  logic [DIVIDER_BITS-1:0] divider;
  logic [DIVIDER_BITS:0]   half;
  logic        mdc_high;
  logic        sample_tick;
  logic        bit_end;
  logic        read_ok;
  frame_sel_t  sel;
  line_t       line;

  assign cfg.ready = 1'b1;
  assign req.ready = !out_valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_divider <= DIV_RESET;
      enable        <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        CFG_CLOCK_DIVIDER: clock_divider <= cfg.data.value;
        CFG_ENABLE:        enable        <= cfg.data.value[0];
        default:           ;
      endcase
    end
  end

  assign divider  = clock_divider[DIVIDER_BITS-1:0];
  assign half     = ({1'b0, divider} + {{DIVIDER_BITS{1'b0}}, 1'b1}) >> 1;
  assign mdc_high = {1'b0, tick_count} >= 17'(half);
  assign bit_end  = tick_count >= 16'(divider);
  assign sample_tick = ({1'b0, tick_count} == 17'(half)) && !sel.is_write;
  assign read_ok  = sel.is_write || ack_seen;

  // frame contents for the current step of the sequence
  always_comb begin
    sel.phy = held_phy;
    if (!extended_mode) begin
      sel.is_write = held_write;
      sel.reg_addr = held_reg[4:0];
      sel.data     = held_data;
    end else begin
      case (frame_step)
        STEP_ADDR_FN: begin
          sel.is_write = 1'b1;
          sel.reg_addr = REG_CTRL;
          sel.data     = CTRL_ADDRESS_FN;
        end
        STEP_ADDR: begin
          sel.is_write = 1'b1;
          sel.reg_addr = REG_ADDR_DATA;
          sel.data     = {8'h00, held_reg};
        end
        STEP_DATA_FN: begin
          sel.is_write = 1'b1;
          sel.reg_addr = REG_CTRL;
          sel.data     = CTRL_DATA_FN;
        end
        default: begin
          sel.is_write = held_write;
          sel.reg_addr = REG_ADDR_DATA;
          sel.data     = held_data;
        end
      endcase
    end
  end

  mdioe_frame u_frame (
    .sel       (sel),
    .bit_index (bit_index),
    .line      (line)
  );

  assign load_request = accept && req.data.operation && enable && !active;

  // next state and result for one request
  always_comb begin
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    frame_step_next     = frame_step;
    active_next         = active;
    extended_mode_next  = extended_mode;
    ack_seen_next       = ack_seen;
    shift_register_next = shift_register;
    result              = '0;
    result.status       = STATUS_OK;

    if (req.data.operation) begin
      if (!enable || active) begin
        result.busy_res = active;
        result.status   = STATUS_REJECTED;
      end else begin
        tick_count_next     = '0;
        bit_index_next      = '0;
        frame_step_next     = STEP_ADDR_FN;
        ack_seen_next       = 1'b0;
        extended_mode_next  = req.data.register_address > {3'b000, LOW5_MAX};
        shift_register_next = '0;
        active_next         = 1'b1;
        result.busy_res     = 1'b1;
      end
    end else if (active && !enable) begin
      // abandoned without a done pulse
      tick_count_next    = '0;
      bit_index_next     = '0;
      frame_step_next    = STEP_ADDR_FN;
      active_next        = 1'b0;
      extended_mode_next = 1'b0;
      ack_seen_next      = 1'b0;
    end else if (active) begin
      result.mdc        = mdc_high;
      result.mdio_out   = line.level;
      result.mdio_drive = line.drive;

      if (sample_tick) begin
        if (bit_index == BIT_TA1) begin
          ack_seen_next = !req.data.mdio_in;
        end else if (bit_index > BIT_TA1) begin
          shift_register_next = {shift_register[14:0], req.data.mdio_in};
        end
      end

      if (bit_end) begin
        tick_count_next = '0;
        if (bit_index != BIT_LAST) begin
          bit_index_next = bit_index + 6'd1;
        end else if (extended_mode && frame_step != STEP_LAST) begin
          frame_step_next = frame_step_t'(frame_step + 2'd1);
          bit_index_next  = '0;
          ack_seen_next   = 1'b0;
        end else begin
          result.done_res     = 1'b1;
          result.acknowledged = read_ok;
          result.read_data    = (!sel.is_write && read_ok) ? shift_register_next : '0;
          result.status       = read_ok ? STATUS_OK : STATUS_NO_ACK;
          bit_index_next      = '0;
          frame_step_next     = STEP_ADDR_FN;
          active_next         = 1'b0;
          extended_mode_next  = 1'b0;
          ack_seen_next       = 1'b0;
        end
      end else begin
        tick_count_next = tick_count + 16'd1;
      end
      result.busy_res = active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      bit_index      <= '0;
      frame_step     <= STEP_ADDR_FN;
      active         <= 1'b0;
      extended_mode  <= 1'b0;
      ack_seen       <= 1'b0;
      shift_register <= '0;
    end else if (accept) begin
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      frame_step     <= frame_step_next;
      active         <= active_next;
      extended_mode  <= extended_mode_next;
      ack_seen       <= ack_seen_next;
      shift_register <= shift_register_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_write <= 1'b0;
      held_phy   <= '0;
      held_reg   <= '0;
      held_data  <= '0;
    end else if (load_request) begin
      held_write <= req.data.is_write;
      held_phy   <= req.data.phy_address;
      held_reg   <= req.data.register_address;
      held_data  <= req.data.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  // idle master keeps its sequencing counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !active |-> (tick_count == '0) && (bit_index == '0) && (frame_step == STEP_ADDR_FN))
    else $error("idle master with nonzero sequencing state");

  // a direct access never leaves the first frame step
  a_direct_step: assert property (@(posedge clk) disable iff (rst)
    !extended_mode |-> frame_step == STEP_ADDR_FN)
    else $error("frame step advanced on a direct access");

  // disabling the master drops a running request on the next tick request
  a_disable_abort: assert property (@(posedge clk) disable iff (rst)
    accept && !req.data.operation && active && !enable |=> !active)
    else $error("request not abandoned while disabled");

  // a done result never carries the rejected code
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    accept && result.done_res |=> out_valid && out_data.status != STATUS_REJECTED)
    else $error("done result with rejected status");

  // a started request always reports busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    load_request |=> active && out_data.busy_res)
    else $error("accepted start did not make the master busy");

endmodule

// ----- rtl/mdioe_frame.sv -----
// level and drive of one clause-22 frame bit
module mdioe_frame (
  input  mdioe_pkg::frame_sel_t sel,
  input  logic [5:0]            bit_index,
  output mdioe_pkg::line_t      line
);
  import mdioe_pkg::*;

  logic [5:0] phy_pos;
  logic [5:0] reg_pos;
  logic [5:0] data_pos;

  assign phy_pos  = BIT_PHY_LAST - bit_index;
  assign reg_pos  = BIT_REG_LAST - bit_index;
  assign data_pos = BIT_LAST - bit_index;

  always_comb begin
    line.drive = 1'b1;
    line.level = 1'b1;
    if (bit_index < BIT_START0) begin
      line.level = 1'b1;
    end else if (bit_index == BIT_START0) begin
      line.level = 1'b0;
    end else if (bit_index == BIT_START1) begin
      line.level = 1'b1;
    end else if (bit_index == BIT_OP0) begin
      line.level = ~sel.is_write;
    end else if (bit_index == BIT_OP1) begin
      line.level = sel.is_write;
    end else if (bit_index <= BIT_PHY_LAST) begin
      line.level = sel.phy[phy_pos[2:0]];
    end else if (bit_index <= BIT_REG_LAST) begin
      line.level = sel.reg_addr[reg_pos[2:0]];
    end else if (!sel.is_write) begin
      // read: turnaround and data are released
      line.level = 1'b0;
      line.drive = 1'b0;
    end else if (bit_index == BIT_TA0) begin
      line.level = 1'b1;
    end else if (bit_index == BIT_TA1) begin
      line.level = 1'b0;
    end else begin
      line.level = sel.data[data_pos[3:0]];
    end
  end

endmodule

// ----- verif/mdioe_scoreboard_pkg.sv -----
// scoreboard class of the mdio master testbench: bus predictor and result checks
`timescale 1ns / 1ps
package mdioe_scoreboard_pkg;
  import mdioe_pkg::*;

  class mdio_scoreboard;
    // register settings as the block sees them
    logic [15:0] divider;
    logic        enabled;
    // bus engine
    int unsigned tick_count;
    logic        mdc_level;
    logic [5:0]  bit_index;
    frame_step_t frame_step;
    logic        active;
    logic        indirect;
    logic        ack_seen;
    logic        held_write;
    logic [4:0]  held_phy;
    logic [7:0]  held_reg;
    logic [15:0] held_data;
    logic [15:0] shift_reg;

    res_t expected_q[$];

    int failures;
    int reported;
    int checked;
    int completed;
    int indirect_started;
    int no_acks;
    int rejected;

    function new();
      divider = DIV_RESET;
      enabled = 1'b0;
      held_write = 1'b0;
      held_phy = '0;
      held_reg = '0;
      held_data = '0;
      shift_reg = '0;
      failures = 0;
      reported = 0;
      checked = 0;
      completed = 0;
      indirect_started = 0;
      no_acks = 0;
      rejected = 0;
      go_idle();
    endfunction

    function void go_idle();
      tick_count = 0;
      mdc_level = 1'b0;
      bit_index = '0;
      frame_step = STEP_ADDR_FN;
      active = 1'b0;
      indirect = 1'b0;
      ack_seen = 1'b0;
    endfunction

    function void write_register(cfg_t c);
      case (c.index)
        CFG_CLOCK_DIVIDER: divider = c.value;
        CFG_ENABLE: enabled = c.value[0];
        default: ;
      endcase
    endfunction

    // one request of the channel: a start or one functional clock tick
    function res_t advance_bus(req_t r);
      res_t e;
      int unsigned half, pos, div, bi;
      logic wr, lvl, drv, ok;
      logic [4:0] rg;
      logic [15:0] dt;
      e = '0;
      if (r.operation) begin
        if (!enabled || active) begin
          e.busy_res = active;
          e.status = STATUS_REJECTED;
          rejected++;
          return e;
        end
        held_write = r.is_write;
        held_phy = r.phy_address;
        held_reg = r.register_address;
        held_data = r.write_data;
        go_idle();
        indirect = (r.register_address > LOW5_MAX);
        if (indirect) indirect_started++;
        shift_reg = '0;
        active = 1'b1;
        e.busy_res = 1'b1;
        return e;
      end
      if (!active) begin
        mdc_level = 1'b0;
        return e;
      end
      // disabled mid-access: dropped without a done pulse
      if (!enabled) begin
        go_idle();
        return e;
      end

      div = divider;
      half = (div + 1) >> 1;
      pos = tick_count;
      bi = bit_index;

      if (!indirect) begin
        wr = held_write;
        rg = held_reg[4:0];
        dt = held_data;
      end else begin
        case (frame_step)
          STEP_ADDR_FN: begin
            wr = 1'b1;
            rg = REG_CTRL;
            dt = CTRL_ADDRESS_FN;
          end
          STEP_ADDR: begin
            wr = 1'b1;
            rg = REG_ADDR_DATA;
            dt = {8'h00, held_reg};
          end
          STEP_DATA_FN: begin
            wr = 1'b1;
            rg = REG_CTRL;
            dt = CTRL_DATA_FN;
          end
          default: begin
            wr = held_write;
            rg = REG_ADDR_DATA;
            dt = held_data;
          end
        endcase
      end

      drv = 1'b1;
      if (bi < BIT_START0) lvl = 1'b1;
      else if (bi == BIT_START0) lvl = 1'b0;
      else if (bi == BIT_START1) lvl = 1'b1;
      else if (bi == BIT_OP0) lvl = !wr;
      else if (bi == BIT_OP1) lvl = wr;
      else if (bi <= BIT_PHY_LAST) lvl = held_phy[BIT_PHY_LAST - bi];
      else if (bi <= BIT_REG_LAST) lvl = rg[BIT_REG_LAST - bi];
      else if (!wr) begin
        lvl = 1'b0;
        drv = 1'b0;
      end
      else if (bi == BIT_TA0) lvl = 1'b1;
      else if (bi == BIT_TA1) lvl = 1'b0;
      else lvl = dt[BIT_LAST - bi];

      mdc_level = (pos >= half);
      e.mdc = mdc_level;
      e.mdio_out = lvl;
      e.mdio_drive = drv;

      // reads sample on the first high tick of the bit
      if (pos == half && !wr) begin
        if (bi == BIT_TA1) ack_seen = !r.mdio_in;
        else if (bi > BIT_TA1) shift_reg = {shift_reg[14:0], r.mdio_in};
      end

      // >= so that a lowered divider ends the current bit at once
      if (pos >= div) begin
        tick_count = 0;
        if (bi < BIT_LAST) begin
          bit_index = bit_index + 1'b1;
        end else if (indirect && frame_step != STEP_LAST) begin
          frame_step = frame_step_t'(frame_step + 1'b1);
          bit_index = '0;
          ack_seen = 1'b0;
        end else begin
          ok = wr || ack_seen;
          e.done_res = 1'b1;
          e.acknowledged = ok;
          e.read_data = (!wr && ok) ? shift_reg : 16'h0000;
          e.status = ok ? STATUS_OK : STATUS_NO_ACK;
          completed++;
          if (!ok) no_acks++;
          go_idle();
        end
      end else begin
        tick_count = pos + 1;
      end
      e.busy_res = active;
      return e;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(advance_bus(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: mdc %b out %b drive %b busy %b done %b ack %b data %h st %0d",
                   got.mdc, got.mdio_out, got.mdio_drive, got.busy_res, got.done_res,
                   got.acknowledged, got.read_data, got.status);
        end
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.mdc !== want.mdc || got.mdio_out !== want.mdio_out ||
          got.mdio_drive !== want.mdio_drive || got.busy_res !== want.busy_res ||
          got.done_res !== want.done_res || got.acknowledged !== want.acknowledged ||
          got.read_data !== want.read_data || got.status !== want.status) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch at result %0d:", checked);
          $display("  expected mdc %b out %b drive %b busy %b done %b ack %b data %h st %0d",
                   want.mdc, want.mdio_out, want.mdio_drive, want.busy_res, want.done_res,
                   want.acknowledged, want.read_data, want.status);
          $display("  actual   mdc %b out %b drive %b busy %b done %b ack %b data %h st %0d",
                   got.mdc, got.mdio_out, got.mdio_drive, got.busy_res, got.done_res,
                   got.acknowledged, got.read_data, got.status);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ----- verif/testbench.sv -----
// top of the mdio master testbench: clock, reset, stimulus, stalls and watchdog
`timescale 1ns / 1ps
module testbench;
  import mdioe_pkg::*;
  import mdioe_scoreboard_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef enum {LINE_RANDOM, LINE_LOW, LINE_HIGH} line_mode_t;

  logic clk;
  logic rst;

  mdioe_req_if req_ch();
  mdioe_res_if res_ch();
  mdioe_cfg_if cfg_ch();

  mdio_master_extended_access_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .res(res_ch)
  );

  mdio_scoreboard sb;
  int items_accepted;
  logic [15:0] cur_divider;
  bit sending;
  int burst_left;
  bit long_hold_wanted;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_register(cfg_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.data);
        items_accepted++;
      end
    end
  end

  // request sender: bursts of random length with gaps in between
  task automatic offer(input req_t item);
    req_ch.data <= item;
    req_ch.valid <= 1'b1;
    sending = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      sending = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
  endtask

  task automatic pause_sender();
    if (sending) begin
      req_ch.valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  task automatic wait_drained();
    pause_sender();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] wdata);
    cfg_t c;
    c.index = idx;
    c.value = wdata;
    cfg_ch.data <= c;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CLOCK_DIVIDER) cur_divider = wdata;
  endtask

  task automatic set_enable(input logic on);
    write_reg(CFG_ENABLE, {15'($urandom), on});
  endtask

  task automatic tick(input logic line);
    req_t r;
    r = req_t'($urandom);
    r.operation = 1'b0;
    r.mdio_in = line;
    offer(r);
  endtask

  task automatic start_access(input logic wr, input logic [4:0] phy, input logic [7:0] rg,
                              input logic [15:0] wdata);
    req_t r;
    r = req_t'($urandom);
    r.operation = 1'b1;
    r.is_write = wr;
    r.phy_address = phy;
    r.register_address = rg;
    r.write_data = wdata;
    offer(r);
  endtask

  // start an access and tick it through to its done pulse
  task automatic run_access(input logic wr, input logic [4:0] phy, input logic [7:0] rg,
                            input logic [15:0] wdata, input line_mode_t mode,
                            input bit poke_busy);
    int n, i;
    logic line;
    n = ((rg > LOW5_MAX) ? 4 : 1) * 64 * (int'(cur_divider) + 1);
    start_access(wr, phy, rg, wdata);
    for (i = 0; i < n; i++) begin
      if (poke_busy && i == n / 2) start_access(1'($urandom), 5'($urandom), 8'($urandom),
                                                16'($urandom));
      case (mode)
        LINE_LOW: line = 1'b0;
        LINE_HIGH: line = 1'b1;
        default: line = 1'($urandom);
      endcase
      tick(line);
    end
  endtask

  // start an access, then switch the master off under it
  task automatic abandon_access(input logic [7:0] rg);
    start_access(1'($urandom), 5'($urandom), rg, 16'($urandom));
    repeat ($urandom_range(1, 60)) tick(1'($urandom));
    wait_drained();
    set_enable(1'b0);
    repeat ($urandom_range(1, 4)) tick(1'($urandom));
    start_access(1'($urandom), 5'($urandom), 8'($urandom), 16'($urandom));
    wait_drained();
    set_enable(1'b1);
  endtask

  initial begin
    int base, completes, kind, pick;
    logic [7:0] rg;
    line_mode_t mode;
    sb = new();
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    sending = 1'b0;
    burst_left = 20;
    long_hold_wanted = 1'b0;
    items_accepted = 0;
    cur_divider = DIV_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // master still off after reset: turned away, lines idle
    start_access(1'b1, 5'h1f, 8'hff, 16'hffff);
    repeat (3) tick(1'($urandom));
    wait_drained();
    write_reg(CFG_CLOCK_DIVIDER, 16'h0000);
    set_enable(1'b1);

    run_access(1'b1, 5'h1f, 8'h1f, 16'hffff, LINE_RANDOM, 1'b0);
    run_access(1'b0, 5'h00, 8'h00, 16'h0000, LINE_LOW, 1'b0);
    run_access(1'b0, 5'h0a, 8'h07, 16'h5a5a, LINE_HIGH, 1'b1);
    run_access(1'b0, 5'h11, 8'hff, 16'h0000, LINE_LOW, 1'b0);
    wait_drained();
    write_reg(CFG_CLOCK_DIVIDER, 16'd1);
    run_access(1'b1, 5'h05, 8'h09, 16'ha5c3, LINE_RANDOM, 1'b0);
    abandon_access(8'h41);

    // largest divider, then lowered in the middle of a bit
    wait_drained();
    write_reg(CFG_CLOCK_DIVIDER, 16'hffff);
    start_access(1'b1, 5'h12, 8'h05, 16'hbeef);
    repeat (20) tick(1'($urandom));
    wait_drained();
    write_reg(CFG_CLOCK_DIVIDER, 16'd0);
    repeat (64 + 8) tick(1'($urandom));
    wait_drained();

    base = items_accepted;
    completes = 0;
    while ((items_accepted - base) < 80) begin
      if (completes % 2 == 0) begin
        wait_drained();
        pick = $urandom_range(0, 2);
        write_reg(CFG_CLOCK_DIVIDER, 16'(pick));
      end
      kind = (completes == 0) ? 9 : $urandom_range(0, 9);
      rg = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(32, 255));
      if (kind == 0) begin
        abandon_access(rg);
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 8)) tick(1'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        mode = (pick < 6) ? LINE_RANDOM : (pick < 8) ? LINE_LOW : LINE_HIGH;
        // receiver holds off once while a long access is being offered
        if (completes == 0) long_hold_wanted = 1'b1;
        run_access(1'($urandom), 5'($urandom), rg, 16'($urandom), mode,
                   $urandom_range(0, 4) == 0);
        completes++;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("run covered %0d finished accesses (%0d indirect started), %0d reads unacknowledged",
             sb.completed, sb.indirect_started, sb.no_acks);
    $display("with %0d requests turned away and %0d results checked, %0d mismatches",
             sb.rejected, sb.checked, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // result side: stretches of full rate, random and sparse acceptance
  initial begin
    int stretch, mode, phase;
    res_ch.ready <= 1'b0;
    stretch = 0;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        phase++;
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= 1'($urandom);
          2: res_ch.ready <= (phase % 4 == 0);
          default: res_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles", quiet);
        $display("testbench failed");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/mdioe_pkg.sv
rtl/mdioe_ifs.sv
rtl/mdioe_frame.sv
rtl/mdio_master_extended_access_core.sv
verif/mdioe_scoreboard_pkg.sv
verif/testbench.sv
